// ----- design/hgd_pkg.sv -----
// Shared types and constants of the headset button gesture decoder.
package hgd_pkg;

    typedef logic [2:0] t_cls;
    typedef logic [3:0] t_event;

    localparam t_cls CLS_OPEN   = 3'd0;
    localparam t_cls CLS_CENTER = 3'd1;
    localparam t_cls CLS_D      = 3'd2;
    localparam t_cls CLS_PLUS   = 3'd3;
    localparam t_cls CLS_MINUS  = 3'd4;

    localparam t_event EV_NONE       = 4'd0;
    localparam t_event EV_C_SINGLE   = 4'd1;
    localparam t_event EV_C_DOUBLE   = 4'd2;
    localparam t_event EV_C_TRIPLE   = 4'd3;
    localparam t_event EV_C_LONG     = 4'd4;
    localparam t_event EV_C_LONGLONG = 4'd5;
    localparam t_event EV_PLUS       = 4'd6;
    localparam t_event EV_PLUS_LONG  = 4'd7;
    localparam t_event EV_MINUS      = 4'd8;
    localparam t_event EV_MINUS_LONG = 4'd9;

    localparam int SAMPLE_W = 10;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_REGS = 7;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_UPPER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_D_LOWER      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_D_UPPER      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLUS_LOWER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLUS_UPPER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MINUS_LOWER  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MINUS_UPPER  = 3'd6;

    localparam logic [SAMPLE_W-1:0] REG_RESET [NUM_REGS] = '{
        10'd31, 10'd44, 10'd73, 10'd74, 10'd124, 10'd134, 10'd224
    };

    localparam int HOLD_W = 6;
    localparam logic [HOLD_W-1:0] HOLD_MAX = 6'd63;

    // Control signals of the history memory.
    typedef struct packed {
        logic rd_en;
        logic shift;
        logic clear;
    } t_mem_ctl;

endpackage

// ----- design/hgd_cfg_class.sv -----
// Window registers and the sample classifier.
module hgd_cfg_class (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hgd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hgd_pkg::SAMPLE_W-1:0]    i_cfg_data,
    input  logic [hgd_pkg::SAMPLE_W-1:0]    i_sample,
    output hgd_pkg::t_cls                   o_cls
);

    logic [hgd_pkg::SAMPLE_W-1:0] r_cfg [hgd_pkg::NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < hgd_pkg::NUM_REGS; k++) begin
                r_cfg[k] <= hgd_pkg::REG_RESET[k];
            end
        end else if (i_cfg_we && (i_cfg_idx < hgd_pkg::CFG_IDX_W'(hgd_pkg::NUM_REGS))) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Windows are tested in a fixed order; the first match wins.
    always_comb begin
        if (i_sample < r_cfg[hgd_pkg::REG_CENTER_UPPER]) begin
            o_cls = hgd_pkg::CLS_CENTER;
        end else if (i_sample >= r_cfg[hgd_pkg::REG_D_LOWER] &&
                     i_sample <  r_cfg[hgd_pkg::REG_D_UPPER]) begin
            o_cls = hgd_pkg::CLS_D;
        end else if (i_sample >= r_cfg[hgd_pkg::REG_PLUS_LOWER] &&
                     i_sample <  r_cfg[hgd_pkg::REG_PLUS_UPPER]) begin
            o_cls = hgd_pkg::CLS_PLUS;
        end else if (i_sample >= r_cfg[hgd_pkg::REG_MINUS_LOWER] &&
                     i_sample <  r_cfg[hgd_pkg::REG_MINUS_UPPER]) begin
            o_cls = hgd_pkg::CLS_MINUS;
        end else begin
            o_cls = hgd_pkg::CLS_OPEN;
        end
    end

endmodule

// ----- design/hgd_hist_mem.sv -----
// Circular class history memory with per-entry valid bits and a registered read port.
module hgd_hist_mem #(
    parameter int DEPTH = 30,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hgd_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_rd_idx,
    input  hgd_pkg::t_cls     i_wr_cls,
    output hgd_pkg::t_cls     o_rd_cls,
    output logic              o_rd_vld
);

    hgd_pkg::t_cls    r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DEPTH-1:0] n_valid;
    logic [AW-1:0]    r_head;
    logic [AW-1:0]    n_head;
    logic [AW:0]      rd_sum;
    logic [AW-1:0]    rd_addr;
    hgd_pkg::t_cls    r_rd_data;
    logic             r_rd_entry_vld;

    // Logical index 0 is the newest entry, stored at the head.
    assign rd_sum  = {1'b0, r_head} + {1'b0, i_rd_idx};
    assign rd_addr = (rd_sum >= (AW+1)'(DEPTH)) ? AW'(rd_sum - (AW+1)'(DEPTH)) : AW'(rd_sum);
    assign n_head  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);

    always_comb begin
        n_valid = i_ctl.clear ? '0 : r_valid;
        n_valid[n_head] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_mem[n_head] <= i_wr_cls;
        end
        if (i_ctl.rd_en) begin
            r_rd_data      <= r_mem[rd_addr];
            r_rd_entry_vld <= r_valid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_head   <= '0;
            o_rd_vld <= 1'b0;
        end else begin
            o_rd_vld <= i_ctl.rd_en;
            if (i_ctl.shift) begin
                r_valid <= n_valid;
                r_head  <= n_head;
            end
        end
    end

    // An entry never written since the last clear reads as open.
    assign o_rd_cls = r_rd_entry_vld ? r_rd_data : hgd_pkg::CLS_OPEN;

endmodule

// ----- design/headset_button_gesture_decoder.sv -----
// Top level of the headset button gesture decoder: tick sequencer and result register.
//
// Usage: one request on the input channel (i_in_valid / o_in_ready) carries one
// button tick: a 10-bit sample of the microphone line and the event_unread flag.
// Each request gives exactly one result on the output channel (o_out_valid /
// i_out_ready): an event code and the button class of that tick.
// Operation: an accepted request scans the history memory one entry per cycle,
// HISTORY_DEPTH reads through its single registered read port, then updates the
// state in S_FIN once the output register is free. A request is taken only in
// the idle state, so no new request is accepted before the last one has finished.
// The window registers are written through i_cfg_we / i_cfg_idx / i_cfg_data,
// one register per cycle; indexes beyond the register list are ignored.
// Reset (synchronous, active low) restores the window defaults, marks every
// history entry open and loads the hold counter with LONG_LONG_TICKS.
// A result waiting in the output register does not block the next request; a
// finished request whose result cannot be placed because the receiver stalls
// waits before updating the state.
module headset_button_gesture_decoder #(
    parameter int HISTORY_DEPTH   = 30,
    parameter int QUIET_TICKS     = 8,
    parameter int LONG_TICKS      = 10,
    parameter int LONG_LONG_TICKS = 30
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [hgd_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic                            i_event_unread,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output hgd_pkg::t_event                 o_event_code,
    output hgd_pkg::t_cls                   o_button_class,
    input  logic                            i_cfg_we,
    input  logic [hgd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hgd_pkg::SAMPLE_W-1:0]    i_cfg_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam bit QUIET_IN_RANGE = (QUIET_TICKS < HISTORY_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]                   r_state;
    logic [hgd_pkg::SAMPLE_W-1:0] r_sample;
    logic                         r_unread;
    logic                         r_issuing;
    logic [AW-1:0]                r_idx;
    logic [AW-1:0]                r_didx;
    logic [hgd_pkg::HOLD_W-1:0]   r_hold;
    logic [hgd_pkg::HOLD_W-1:0]   n_hold;
    logic [hgd_pkg::HOLD_W-1:0]   hold_inc;
    hgd_pkg::t_cls                r_prev;
    hgd_pkg::t_cls                r_atq;
    hgd_pkg::t_cls                r_last;
    logic                         r_quiet_ok;
    logic                         r_pressed;
    logic [2:0]                   r_count;
    logic                         r_out_valid;
    hgd_pkg::t_event              r_event;
    hgd_pkg::t_cls                r_class;

    hgd_pkg::t_cls                cls;
    hgd_pkg::t_cls                rd_cls;
    logic                         rd_vld;
    hgd_pkg::t_mem_ctl            mem_ctl;
    hgd_pkg::t_event              ev;
    logic                         clr;
    logic                         in_acc;
    logic                         out_free;
    logic                         commit;
    logic                         plus_like;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign commit     = (r_state == S_FIN) && out_free;

    hgd_cfg_class u_cfg_class (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (r_sample),
        .o_cls      (cls)
    );

    assign mem_ctl.rd_en = (r_state == S_SCAN) && r_issuing;
    assign mem_ctl.shift = commit;
    assign mem_ctl.clear = commit && clr;

    hgd_hist_mem #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mem_ctl),
        .i_rd_idx (r_idx),
        .i_wr_cls (cls),
        .o_rd_cls (rd_cls),
        .o_rd_vld (rd_vld)
    );

    // Sequencer and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issuing   <= 1'b0;
            r_idx       <= '0;
            r_hold      <= hgd_pkg::HOLD_W'(LONG_LONG_TICKS);
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !commit) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state   <= S_SCAN;
                        r_issuing <= 1'b1;
                        r_idx     <= '0;
                    end
                end
                S_SCAN: begin
                    if (r_issuing) begin
                        if (r_idx == AW'(HISTORY_DEPTH - 1)) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_idx <= r_idx + AW'(1);
                        end
                    end
                    if (rd_vld && r_didx == AW'(HISTORY_DEPTH - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state     <= S_IDLE;
                        r_hold      <= n_hold;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Per-request datapath: captured request, scan results and result payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample   <= i_sample;
            r_unread   <= i_event_unread;
            r_prev     <= hgd_pkg::CLS_OPEN;
            r_atq      <= hgd_pkg::CLS_OPEN;
            r_last     <= hgd_pkg::CLS_OPEN;
            r_quiet_ok <= 1'b1;
            r_pressed  <= 1'b0;
            r_count    <= '0;
        end
        if (mem_ctl.rd_en) begin
            r_didx <= r_idx;
        end
        if (rd_vld) begin
            r_last <= rd_cls;
            if (r_didx == '0) begin
                r_prev <= rd_cls;
            end
            if (32'(r_didx) < QUIET_TICKS) begin
                if (rd_cls != hgd_pkg::CLS_OPEN) begin
                    r_quiet_ok <= 1'b0;
                end
            end else begin
                if (QUIET_IN_RANGE && 32'(r_didx) == QUIET_TICKS) begin
                    r_atq <= rd_cls;
                end
                // A click is a press edge followed by a release edge.
                if (!r_pressed && r_last == hgd_pkg::CLS_OPEN &&
                    rd_cls == hgd_pkg::CLS_CENTER) begin
                    r_pressed <= 1'b1;
                end else if (r_pressed && r_last == hgd_pkg::CLS_CENTER &&
                             rd_cls == hgd_pkg::CLS_OPEN) begin
                    r_pressed <= 1'b0;
                    if (r_count != 3'd4) begin
                        r_count <= r_count + 3'd1;
                    end
                end
            end
        end
        if (commit) begin
            r_event <= ev;
            r_class <= cls;
        end
    end

    assign plus_like = (cls == hgd_pkg::CLS_D) || (cls == hgd_pkg::CLS_PLUS);
    assign hold_inc  = (r_hold == hgd_pkg::HOLD_MAX) ? r_hold
                                                     : r_hold + hgd_pkg::HOLD_W'(1);

    // Gesture decision from this tick's class, the scan results and the hold count.
    always_comb begin
        ev     = hgd_pkg::EV_NONE;
        n_hold = r_hold;
        clr    = 1'b0;
        if (cls == hgd_pkg::CLS_OPEN) begin
            n_hold = '0;
            if (r_hold > hgd_pkg::HOLD_W'(LONG_TICKS)) begin
                // Release after a long push wipes the history, so no click counts.
                clr = 1'b1;
            end else if (r_atq == hgd_pkg::CLS_CENTER && r_quiet_ok && r_count != '0) begin
                clr = 1'b1;
                case (r_count)
                    3'd1:    ev = hgd_pkg::EV_C_SINGLE;
                    3'd2:    ev = hgd_pkg::EV_C_DOUBLE;
                    3'd3:    ev = hgd_pkg::EV_C_TRIPLE;
                    default: ev = hgd_pkg::EV_NONE;
                endcase
            end
        end else if (r_prev == hgd_pkg::CLS_OPEN) begin
            if (plus_like) begin
                ev = hgd_pkg::EV_PLUS;
            end else if (cls == hgd_pkg::CLS_MINUS) begin
                ev = hgd_pkg::EV_MINUS;
            end
        end else if (r_hold == hgd_pkg::HOLD_W'(LONG_TICKS)) begin
            // Plus and minus stay at this count, so their long push repeats.
            if (cls == hgd_pkg::CLS_CENTER) begin
                ev     = hgd_pkg::EV_C_LONG;
                n_hold = hold_inc;
            end else if (plus_like) begin
                ev = hgd_pkg::EV_PLUS_LONG;
            end else if (cls == hgd_pkg::CLS_MINUS) begin
                ev = hgd_pkg::EV_MINUS_LONG;
            end
        end else if (r_hold == hgd_pkg::HOLD_W'(LONG_LONG_TICKS)) begin
            if (cls == hgd_pkg::CLS_CENTER) begin
                ev = hgd_pkg::EV_C_LONGLONG;
            end
            n_hold = hold_inc;
        end else if (cls == r_prev) begin
            n_hold = hold_inc;
        end
        if (r_unread) begin
            ev = hgd_pkg::EV_NONE;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_code   = r_event;
    assign o_button_class = r_class;

`ifndef NO_ASSERTIONS
    a_unread_suppresses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_unread) |=> (o_event_code == hgd_pkg::EV_NONE))
        else $error("event signalled while the previous one is unread");

    a_open_clears_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && cls == hgd_pkg::CLS_OPEN) |=> (r_hold == '0))
        else $error("hold count not cleared on an open tick");

    a_plus_event_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_code == hgd_pkg::EV_PLUS ||
                         o_event_code == hgd_pkg::EV_PLUS_LONG))
        |-> (o_button_class == hgd_pkg::CLS_D || o_button_class == hgd_pkg::CLS_PLUS))
        else $error("plus event with a class other than D or plus");

    a_read_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_vld |-> (r_state == S_SCAN))
        else $error("history read data returned outside the scan");
`endif

endmodule

// ----- bench/hgd_checker.sv -----
// Checker for the gesture decoder: tracks windows and history, predicts and compares each result.
`timescale 1ns / 1ps
module hgd_checker
    import hgd_pkg::*;
#(
    parameter int HISTORY_DEPTH   = 30,
    parameter int QUIET_TICKS     = 8,
    parameter int LONG_TICKS      = 10,
    parameter int LONG_LONG_TICKS = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_event_unread,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_event                i_event_code,
    input  t_cls                  i_button_class,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [SAMPLE_W-1:0]   i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_gestures,
    output int                    o_clicks
);

    typedef struct packed {
        t_event event_code;
        t_cls   button_class;
    } t_tick_result;

    t_tick_result        awaited_results[$];
    logic [SAMPLE_W-1:0] windows [NUM_REGS];
    t_cls                class_hist [HISTORY_DEPTH];
    logic [HOLD_W-1:0]   hold;
    int                  fail_cnt;
    int                  checked_cnt;
    int                  gesture_cnt;
    int                  click_cnt;

    function automatic t_cls hist_at(int i);
        if (i >= HISTORY_DEPTH) return CLS_OPEN;
        return class_hist[i];
    endfunction

    function automatic void clear_history();
        foreach (class_hist[i]) class_hist[i] = CLS_OPEN;
    endfunction

    function automatic void bump_hold();
        if (hold < HOLD_MAX) hold = hold + 1'b1;
    endfunction

    function automatic t_cls classify(logic [SAMPLE_W-1:0] s);
        if (s < windows[REG_CENTER_UPPER]) return CLS_CENTER;
        if (s >= windows[REG_D_LOWER] && s < windows[REG_D_UPPER]) return CLS_D;
        if (s >= windows[REG_PLUS_LOWER] && s < windows[REG_PLUS_UPPER]) return CLS_PLUS;
        if (s >= windows[REG_MINUS_LOWER] && s < windows[REG_MINUS_UPPER]) return CLS_MINUS;
        return CLS_OPEN;
    endfunction

    // Counts press/release pairs behind the quiet stretch; any nonzero count
    // consumes the history.
    function automatic int count_clicks();
        int   n;
        bit   pressed;
        t_cls a;
        t_cls b;
        n = 0;
        pressed = 1'b0;
        for (int i = 0; i < QUIET_TICKS; i++) begin
            if (hist_at(i) != CLS_OPEN) return 0;
        end
        for (int i = QUIET_TICKS; i < HISTORY_DEPTH; i++) begin
            a = hist_at(i - 1);
            b = hist_at(i);
            if (!pressed && a == CLS_OPEN && b == CLS_CENTER) begin
                pressed = 1'b1;
            end else if (pressed && a == CLS_CENTER && b == CLS_OPEN) begin
                n++;
                pressed = 1'b0;
            end
        end
        if (n > 0) clear_history();
        return n;
    endfunction

    function automatic t_tick_result predict_tick(logic [SAMPLE_W-1:0] s, logic unread);
        t_tick_result res;
        t_cls         cls;
        t_cls         prev;
        t_event       ev;
        bit           plus_like;
        cls = classify(s);
        prev = hist_at(0);
        ev = EV_NONE;
        plus_like = (cls == CLS_D) || (cls == CLS_PLUS);

        if (cls == CLS_OPEN) begin
            // Releasing a long push wipes the history so it never reads as a click.
            if (hold > LONG_TICKS) clear_history();
            hold = '0;
            if (hist_at(QUIET_TICKS) == CLS_CENTER) begin
                case (count_clicks())
                    1: ev = EV_C_SINGLE;
                    2: ev = EV_C_DOUBLE;
                    3: ev = EV_C_TRIPLE;
                    default: ev = EV_NONE;
                endcase
            end
        end else if (prev == CLS_OPEN) begin
            if (plus_like) ev = EV_PLUS;
            else if (cls == CLS_MINUS) ev = EV_MINUS;
        end else if (hold == LONG_TICKS) begin
            if (cls == CLS_CENTER) begin
                ev = EV_C_LONG;
                bump_hold();
            end else if (plus_like) begin
                ev = EV_PLUS_LONG;
            end else if (cls == CLS_MINUS) begin
                ev = EV_MINUS_LONG;
            end
        end else if (hold == LONG_LONG_TICKS) begin
            if (cls == CLS_CENTER) ev = EV_C_LONGLONG;
            bump_hold();
        end else if (cls == prev) begin
            bump_hold();
        end

        for (int i = HISTORY_DEPTH - 1; i > 0; i--) class_hist[i] = class_hist[i - 1];
        class_hist[0] = cls;

        if (unread) ev = EV_NONE;
        res.event_code = ev;
        res.button_class = cls;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_tick_result want;
        if (!i_rst_n) begin
            foreach (windows[i]) windows[i] = REG_RESET[i];
            clear_history();
            hold = HOLD_W'(LONG_LONG_TICKS);
            awaited_results.delete();
        end else begin
            if (i_cfg_we && i_cfg_idx < NUM_REGS) windows[i_cfg_idx] = i_cfg_data;

            if (i_in_valid && i_in_ready)
                awaited_results.push_back(predict_tick(i_sample, i_event_unread));

            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: event_code %0d button_class %0d",
                           i_event_code, i_button_class);
                    fail_cnt++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_event_code !== want.event_code) begin
                        $error("event_code mismatch: expected %0d, actual %0d",
                               want.event_code, i_event_code);
                        fail_cnt++;
                    end
                    if (i_button_class !== want.button_class) begin
                        $error("button_class mismatch: expected %0d, actual %0d",
                               want.button_class, i_button_class);
                        fail_cnt++;
                    end
                    checked_cnt++;
                    if (want.event_code != EV_NONE) gesture_cnt++;
                    if (want.event_code == EV_C_SINGLE || want.event_code == EV_C_DOUBLE ||
                        want.event_code == EV_C_TRIPLE)
                        click_cnt++;
                end
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= awaited_results.size();
        o_checked    <= checked_cnt;
        o_gestures   <= gesture_cnt;
        o_clicks     <= click_cnt;
    end

endmodule

// ----- bench/tb_headset_button_gesture_decoder.sv -----
// Testbench top for the gesture decoder: drives ticks and window settings, gives the verdict.
`timescale 1ns / 1ps
module tb_headset_button_gesture_decoder;
    import hgd_pkg::*;

    localparam int HISTORY_DEPTH   = 30;
    localparam int QUIET_TICKS     = 8;
    localparam int LONG_TICKS      = 10;
    localparam int LONG_LONG_TICKS = 30;
    localparam int SETTLE_CYCLES   = HISTORY_DEPTH + 20;
    localparam int HOLDOFF_CYCLES  = 600;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // Window edges under the reset settings, each mostly following an open tick.
    localparam logic [SAMPLE_W-1:0] EDGE_SAMPLES [24] = '{
        10'd0, 10'd0, 10'd1023, 10'd30, 10'd1023, 10'd31, 10'd43, 10'd44,
        10'd1023, 10'd72, 10'd73, 10'd74, 10'd1023, 10'd123, 10'd124, 10'd133,
        10'd134, 10'd1023, 10'd223, 10'd224, 10'd1023, 10'd512, 10'd0, 10'd1023
    };
    localparam logic [23:0] EDGE_UNREAD = 24'h240000;

    typedef enum int {WIN_DEFAULT, WIN_SPREAD, WIN_ALL_LOW, WIN_ALL_HIGH, WIN_SCRAMBLED}
        t_win_setting;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [SAMPLE_W-1:0]  in_sample = '0;
    logic                 in_unread = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_event               out_event;
    t_cls                 out_class;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [SAMPLE_W-1:0]  cfg_data  = '0;

    int fail_count;
    int pending;
    int checked;
    int gestures;
    int clicks;

    logic [SAMPLE_W-1:0] windows [NUM_REGS];
    int burst_left;
    int sent;
    int settings_used;
    int holdoffs;

    headset_button_gesture_decoder #(
        .HISTORY_DEPTH  (HISTORY_DEPTH),
        .QUIET_TICKS    (QUIET_TICKS),
        .LONG_TICKS     (LONG_TICKS),
        .LONG_LONG_TICKS(LONG_LONG_TICKS)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_sample      (in_sample),
        .i_event_unread(in_unread),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_event_code  (out_event),
        .o_button_class(out_class),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    hgd_checker #(
        .HISTORY_DEPTH  (HISTORY_DEPTH),
        .QUIET_TICKS    (QUIET_TICKS),
        .LONG_TICKS     (LONG_TICKS),
        .LONG_LONG_TICKS(LONG_LONG_TICKS)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_sample      (in_sample),
        .i_event_unread(in_unread),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_event_code  (out_event),
        .i_button_class(out_class),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_gestures    (gestures),
        .o_clicks      (clicks)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2_500_000;
        $display("simulation failed");
        $finish;
    end

    // Receiver: random ready runs and stalls, plus deliberate long hold-offs that
    // back the block up until it refuses new requests.
    initial begin : receiver
        int cycles;
        int run;
        cycles = 0;
        holdoffs = 0;
        @(posedge clk);
        forever begin
            if ((cycles >= 3000 && holdoffs == 0) || (cycles >= 60000 && holdoffs == 1)) begin
                out_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
                cycles += HOLDOFF_CYCLES;
                holdoffs++;
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            cycles += run;
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
            out_ready <= 1'b0;
            repeat (run) @(posedge clk);
            cycles += run;
        end
    end

    task automatic send_tick(input logic [SAMPLE_W-1:0] s, input logic unread);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        in_sample <= s;
        in_unread <= unread;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        sent++;
    endtask

    function automatic logic [SAMPLE_W-1:0] sample_for(t_cls c);
        int lo;
        int hi;
        lo = 0;
        hi = 0;
        case (c)
            CLS_CENTER: hi = int'(windows[REG_CENTER_UPPER]);
            CLS_D: begin
                lo = int'(windows[REG_D_LOWER]);
                hi = int'(windows[REG_D_UPPER]);
            end
            CLS_PLUS: begin
                lo = int'(windows[REG_PLUS_LOWER]);
                hi = int'(windows[REG_PLUS_UPPER]);
            end
            CLS_MINUS: begin
                lo = int'(windows[REG_MINUS_LOWER]);
                hi = int'(windows[REG_MINUS_UPPER]);
            end
            default: return SAMPLE_W'($urandom_range(32'(windows[REG_MINUS_UPPER]), 1023));
        endcase
        if (hi > lo) return SAMPLE_W'($urandom_range(lo, hi - 1));
        return SAMPLE_W'($urandom_range(0, 1023));
    endfunction

    function automatic t_cls pick_button(bit with_center);
        case ($urandom_range(with_center ? 0 : 1, 3))
            0: return CLS_CENTER;
            1: return CLS_D;
            2: return CLS_PLUS;
            default: return CLS_MINUS;
        endcase
    endfunction

    task automatic hold_class(t_cls c, int ticks);
        repeat (ticks) send_tick(sample_for(c), $urandom_range(0, 11) == 0);
    endtask

    // One gesture: click bursts, short presses, long and saturating holds, or noise.
    task automatic send_gesture();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            repeat ($urandom_range(1, 5)) begin
                hold_class(CLS_CENTER, $urandom_range(1, 3));
                hold_class(CLS_OPEN, $urandom_range(1, 3));
            end
            hold_class(CLS_OPEN, $urandom_range(6, 14));
        end else if (kind < 60) begin
            hold_class(pick_button(1'b0), $urandom_range(1, 9));
            hold_class(CLS_OPEN, $urandom_range(1, 4));
        end else if (kind < 78) begin
            hold_class(pick_button(1'b1), $urandom_range(10, 40));
            hold_class(CLS_OPEN, $urandom_range(1, 10));
        end else if (kind < 83) begin
            hold_class(pick_button(1'b1), $urandom_range(60, 75));
            hold_class(CLS_OPEN, $urandom_range(1, 4));
        end else begin
            repeat ($urandom_range(1, 6))
                send_tick(SAMPLE_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic finish_phase();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int items);
        int target;
        target = sent + items;
        while (sent < target) send_gesture();
        finish_phase();
    endtask

    task automatic set_windows(t_win_setting setting);
        int pos;
        case (setting)
            WIN_DEFAULT:  foreach (windows[i]) windows[i] = REG_RESET[i];
            WIN_ALL_LOW:  foreach (windows[i]) windows[i] = '0;
            WIN_ALL_HIGH: foreach (windows[i]) windows[i] = '1;
            WIN_SCRAMBLED: foreach (windows[i]) windows[i] = SAMPLE_W'($urandom_range(0, 1023));
            default: begin
                pos = $urandom_range(1, 60);
                windows[REG_CENTER_UPPER] = SAMPLE_W'(pos);
                pos += $urandom_range(0, 20);
                windows[REG_D_LOWER] = SAMPLE_W'(pos);
                pos += $urandom_range(1, 60);
                windows[REG_D_UPPER] = SAMPLE_W'(pos);
                pos += $urandom_range(0, 10);
                windows[REG_PLUS_LOWER] = SAMPLE_W'(pos);
                pos += $urandom_range(1, 100);
                windows[REG_PLUS_UPPER] = SAMPLE_W'(pos);
                pos += $urandom_range(0, 30);
                windows[REG_MINUS_LOWER] = SAMPLE_W'(pos);
                pos += $urandom_range(1, 300);
                windows[REG_MINUS_UPPER] = SAMPLE_W'(pos);
            end
        endcase
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IDX_W'(i);
            cfg_data <= windows[i];
            @(posedge clk);
        end
        // A write past the register list must leave every window alone.
        cfg_idx  <= REG_UNUSED;
        cfg_data <= SAMPLE_W'($urandom_range(0, 1023));
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin : stimulus
        burst_left = 0;
        sent = 0;
        settings_used = 1;
        foreach (windows[i]) windows[i] = REG_RESET[i];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (EDGE_SAMPLES[i]) send_tick(EDGE_SAMPLES[i], EDGE_UNREAD[i]);
        run_phase(400);

        set_windows(WIN_SPREAD);
        run_phase(350);
        set_windows(WIN_ALL_LOW);
        run_phase(60);
        set_windows(WIN_ALL_HIGH);
        run_phase(80);
        set_windows(WIN_SCRAMBLED);
        run_phase(300);
        set_windows(WIN_SPREAD);
        run_phase(350);
        set_windows(WIN_DEFAULT);
        run_phase(200);

        $display("Run covered %0d ticks under %0d window settings, %0d results checked.",
                 sent, settings_used, checked);
        $display("%0d gestures signalled (%0d center clicks); output held off %0d times.",
                 gestures, clicks, holdoffs);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
